[rtl/core/erb_pkg.sv]
package erb_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int MAX_BUCKETS = 16;
    localparam int AW          = $clog2(MAX_ITEMS);
    localparam int CW          = AW + 1;
    localparam int BW          = $clog2(MAX_BUCKETS);
    localparam int BCW         = 5;
    localparam int REMW        = CW + 1;

    localparam logic REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic signed [31:0] income_value;
        logic [15:0]        slot_index;
        logic               included;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic [15:0]   result_slot;
        logic [BW-1:0] bucket;
        logic          overflowed;
        logic          last_result;
    } out_item_t;

endpackage

[rtl/core/erb_ram.sv]
module erb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/erb_ctrl.sv]
module erb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  erb_pkg::in_item_t             in_item,
    input  logic [erb_pkg::BCW-1:0]       bucket_count,
    output logic                          busy,
    output logic                          result_valid,
    output erb_pkg::out_item_t            result,
    output logic                          a_we,
    output logic [erb_pkg::AW-1:0]        a_waddr,
    output logic [47:0]                   a_wdata,
    output logic [erb_pkg::AW-1:0]        a_raddr,
    input  logic [47:0]                   a_rdata,
    output logic                          b_we,
    output logic [erb_pkg::AW-1:0]        b_waddr,
    output logic [15:0]                   b_wdata,
    output logic [erb_pkg::AW-1:0]        b_raddr,
    input  logic [15:0]                   b_rdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_HOLD, S_SCAN, S_WRITE, S_READ, S_DIV, S_EMIT
    } state_t;

    localparam logic [erb_pkg::CW-1:0] MAXC = erb_pkg::CW'(erb_pkg::MAX_ITEMS);
    localparam logic [erb_pkg::BCW-1:0] MAXB = erb_pkg::BCW'(erb_pkg::MAX_BUCKETS);

    state_t state_reg;
    logic [erb_pkg::CW-1:0]   count_reg, n_reg, i_reg, j_reg, jd_reg, rank_reg, r_reg;
    logic                     ovf_reg, pend_reg;
    logic signed [31:0]       vi_reg;
    logic [15:0]              si_reg;
    logic [erb_pkg::BCW-1:0]  b_reg;
    logic [erb_pkg::REMW-1:0] rem_reg;
    logic [erb_pkg::BW-1:0]   q_reg;
    logic                     valid_reg;
    erb_pkg::out_item_t       result_reg;

    logic                     accept, do_store;
    logic [erb_pkg::CW-1:0]   count_next;
    logic [erb_pkg::BCW-1:0]  bsat;
    logic signed [31:0]       vj;
    logic [15:0]              sj;
    logic                     j_before;

    assign accept     = start && (state_reg == S_IDLE);
    assign do_store   = accept && in_item.included && (count_reg < MAXC);
    assign count_next = do_store ? count_reg + 1'b1 : count_reg;
    assign bsat       = (bucket_count > MAXB) ? MAXB : bucket_count;

    assign vj = a_rdata[47:16];
    assign sj = a_rdata[15:0];
    assign j_before = (vj < vi_reg) ||
                      ((vj == vi_reg) && ((sj < si_reg) ||
                       ((sj == si_reg) && (jd_reg < i_reg))));

    assign a_we    = do_store;
    assign a_waddr = count_reg[erb_pkg::AW-1:0];
    assign a_wdata = {in_item.income_value, in_item.slot_index};
    assign a_raddr = (state_reg == S_SCAN) ? j_reg[erb_pkg::AW-1:0] : i_reg[erb_pkg::AW-1:0];
    assign b_we    = (state_reg == S_WRITE);
    assign b_waddr = rank_reg[erb_pkg::AW-1:0];
    assign b_wdata = si_reg;
    assign b_raddr = r_reg[erb_pkg::AW-1:0];

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            jd_reg    <= '0;
            rank_reg  <= '0;
            r_reg     <= '0;
            b_reg     <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
        end
        else
        begin
            valid_reg <= (state_reg == S_EMIT);
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_item.last_item && ((count_next == '0) || (bsat == '0)))
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_next;
                            if (in_item.included && !do_store)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            if (in_item.last_item)
                            begin
                                n_reg     <= count_next;
                                b_reg     <= bsat;
                                i_reg     <= '0;
                                state_reg <= S_LOAD;
                            end
                        end
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    vi_reg    <= vj;
                    si_reg    <= sj;
                    rank_reg  <= '0;
                    j_reg     <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (pend_reg && j_before)
                    begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                    if (j_reg != n_reg)
                    begin
                        pend_reg <= 1'b1;
                        jd_reg   <= j_reg;
                        j_reg    <= j_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        r_reg     <= '0;
                        q_reg     <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_reg >= erb_pkg::REMW'(n_reg))
                    begin
                        rem_reg <= rem_reg - erb_pkg::REMW'(n_reg);
                        q_reg   <= q_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    result_reg.result_slot <= b_rdata;
                    result_reg.bucket      <= q_reg;
                    result_reg.overflowed  <= ovf_reg;
                    result_reg.last_result <= (r_reg + 1'b1 == n_reg);
                    rem_reg <= rem_reg + erb_pkg::REMW'(b_reg);
                    r_reg   <= r_reg + 1'b1;
                    if (r_reg + 1'b1 == n_reg)
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("item count above capacity");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> !valid_reg)
        else $error("result strobe held");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.last_result) |-> (count_reg == '0 && !ovf_reg && !busy))
        else $error("batch state not cleared after final result");

endmodule

[rtl/core/equal_rank_bucket_assigner_top.sv]
// After the last item, each stored item is ranked against all others, then results are emitted in rank order.
// Throughput: one item per cycle while collecting; the ranking pass rereads the item memory
// once per stored item, so batch time grows with the square of the included-item count.
// Results are one-cycle strobes and cannot be stalled by the receiver.
// Reset: rst_n is asynchronous, active low; clears counts, flags and bucket_count to 5.
module equal_rank_bucket_assigner_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  erb_pkg::in_item_t   in_item,
    output logic                busy,
    output logic                result_valid,
    output erb_pkg::out_item_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [erb_pkg::BCW-1:0] bucket_count_reg;
    logic                    a_we, b_we;
    logic [erb_pkg::AW-1:0]  a_waddr, a_raddr, b_waddr, b_raddr;
    logic [47:0]             a_wdata, a_rdata;
    logic [15:0]             b_wdata, b_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == erb_pkg::REG_BUCKET_COUNT) ?
                    {{(32-erb_pkg::BCW){1'b0}}, bucket_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= erb_pkg::BCW'(5);
        end
        else if (psel && penable && pwrite && (paddr[2] == erb_pkg::REG_BUCKET_COUNT))
        begin
            bucket_count_reg <= pwdata[erb_pkg::BCW-1:0];
        end
    end

    erb_ram #(.WIDTH(48), .DEPTH(erb_pkg::MAX_ITEMS)) u_item_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    erb_ram #(.WIDTH(16), .DEPTH(erb_pkg::MAX_ITEMS)) u_rank_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    erb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_item      (in_item),
        .bucket_count (bucket_count_reg),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .a_we         (a_we),
        .a_waddr      (a_waddr),
        .a_wdata      (a_wdata),
        .a_raddr      (a_raddr),
        .a_rdata      (a_rdata),
        .b_we         (b_we),
        .b_waddr      (b_waddr),
        .b_wdata      (b_wdata),
        .b_raddr      (b_raddr),
        .b_rdata      (b_rdata)
    );

endmodule
